### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared constants for the point-in-polygon test core
// Default coordinate width, tolerance register format, multiplier digit and result layout.
// ----------------------------------------------------------------------------
package pip_pkg;

	// default coordinate width, signed two's complement
	localparam int COORD_BITS_DEF = 32;

	// tolerance register
	localparam int             TOL_BITS  = 16;
	localparam logic [15:0]    TOL_RESET = 16'd1;

	// bits of the multiplier operand consumed per cycle
	localparam int DIG_BITS = 8;

	// result byte layout
	localparam int OUT_INSIDE_BIT = 0;
	localparam int OUT_BOUND_BIT  = 1;

endpackage

### rtl/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core: even-odd ray-casting point-in-polygon test
// Tests a query point against a streamed polygon with a tolerance, using one
// shared digit-serial multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tuser[0] = 0 loads the query point and starts a new
//   polygon, tuser[0] = 1 is a vertex. tdata holds x (low) and y (high), each
//   COORD_BITS signed. tlast marks the final vertex, or a query with no
//   vertices; only that request yields a result on m_*.
//   cfg_valid/cfg_data write the tolerance (LSBs of the coordinate format);
//   write it only while the core is idle. cfg_ready is always high.
//   m_tdata[0] = inside, m_tdata[1] = on boundary.
// Timing:
//   s_tready is high only while the sequencer is idle. A vertex costs one
//   edge evaluation: a bounding-box check, then up to five products and two
//   checks (hit, crossing). The final vertex also evaluates the closing
//   edge. The shared multiplier works in NDIG = ceil((COORD_BITS+2)/8) digits
//   of 8 bits and sets the cost of each product. The first vertex of a polygon,
//   if not last, is stored and the core is idle again in the next cycle.
// Reset and stall:
//   Reset clears the point to zero, the tolerance to one and all flags.
//   A result waits in the output register while m_tready is low; the core
//   keeps taking requests and only holds when a second result is ready.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core #(
	parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration: tolerance write
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [pip_pkg::TOL_BITS-1:0]              cfg_data,
	// request stream
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// s_tdata, low bit up: coord_x, coord_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]         s_tdata,
	// s_tuser: func
	input  logic [0:0]                                s_tuser,
	input  logic                                      s_tlast,
	// result stream
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// m_tdata, low bit up: inside_res, on_boundary, zero fill
	output logic [7:0]                                m_tdata
);
	import pip_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int MW   = CB + 2;                 // extended operand width
	localparam int AW   = 2 * MW + 1;             // accumulator width
	localparam int NDIG = (MW + DIG_BITS - 1) / DIG_BITS;
	localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_BOX    = 8'b0000_0010,
		S_LOAD   = 8'b0000_0100,
		S_MUL    = 8'b0000_1000,
		S_HITCHK = 8'b0001_0000,
		S_CRSCHK = 8'b0010_0000,
		S_NEXT   = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		PH_DIFF_A  = 3'd0,
		PH_DIFF_B  = 3'd1,
		PH_LIM     = 3'd2,
		PH_CROSS_A = 3'd3,
		PH_CROSS_B = 3'd4
	} phase_t;

	function automatic logic signed [MW-1:0] sx(input logic [CB-1:0] v);
		sx = {{(MW-CB){v[CB-1]}}, v};
	endfunction

	function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
		mag = v[MW-1] ? (~v + MW'(1)) : v;
	endfunction

	// control state
	state_t              state_q;
	phase_t              phase_q;
	logic [CW-1:0]       cnt_q;
	logic                seen_q, parity_q, hit_q;
	logic                close_q, last_q, cross_q;
	logic                m_valid_q;
	logic [TOL_BITS-1:0] eps_q;
	logic [CB-1:0]       px_q, py_q;

	// payload
	logic [CB-1:0]       first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CB-1:0]       xj_q, yj_q, xi_q, yi_q;
	logic [AW-1:0]       a_sh_q;
	logic [MW-1:0]       b_sh_q;
	logic                neg_q;
	logic signed [AW-1:0] acc_q, diff_q;
	logic [1:0]          out_q;

	logic                s_acc, out_free;
	logic [CB-1:0]       x_in, y_in;
	logic                is_vertex;

	assign s_acc     = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign x_in      = s_tdata[CB-1:0];
	assign y_in      = s_tdata[2*CB-1:CB];
	assign is_vertex = s_tuser[0];

	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {6'b0, out_q};

	// edge geometry
	logic signed [MW-1:0] pxe, pye, xje, yje, xie, yie, epe;
	logic signed [MW-1:0] dx, dy, adx;
	logic                 in_box, flat, ilt, jlt, cross_cond;

	always_comb begin
		pxe = sx(px_q);
		pye = sx(py_q);
		xje = sx(xj_q);
		yje = sx(yj_q);
		xie = sx(xi_q);
		yie = sx(yi_q);
		epe = {{(MW-TOL_BITS){1'b0}}, eps_q};
		dx  = xie - xje;
		dy  = yie - yje;
		adx = mag(dx);
		in_box = ((pxe >= xje - epe) || (pxe >= xie - epe)) &&
		         ((pxe <= xje + epe) || (pxe <= xie + epe)) &&
		         ((pye >= yje - epe) || (pye >= yie - epe)) &&
		         ((pye <= yje + epe) || (pye <= yie + epe));
		flat = (adx <= epe);
		ilt  = (yie < pye - epe);
		jlt  = (yje < pye - epe);
		cross_cond = (ilt ^ jlt) && ((xie <= pxe + epe) || (xje <= pxe + epe));
	end

	// operand select for the shared multiplier
	logic signed [MW-1:0] op_a, op_b;
	logic                 op_sub, op_clr;

	always_comb begin
		op_a   = pye - yje;
		op_b   = dx;
		op_sub = 1'b0;
		op_clr = 1'b1;
		case (phase_q)
			PH_DIFF_A: begin
				op_a = pye - yje;  op_b = dx;         op_sub = 1'b0; op_clr = 1'b1;
			end
			PH_DIFF_B: begin
				op_a = dy;         op_b = pxe - xje;  op_sub = 1'b1; op_clr = 1'b0;
			end
			PH_LIM: begin
				op_a = epe;        op_b = adx;        op_sub = 1'b0; op_clr = 1'b1;
			end
			PH_CROSS_A: begin
				op_a = pye - yie;  op_b = xje - xie;  op_sub = 1'b0; op_clr = 1'b1;
			end
			PH_CROSS_B: begin
				op_a = pxe - epe - xie; op_b = yje - yie; op_sub = 1'b1; op_clr = 1'b0;
			end
			default: begin
				op_a = pye - yje;  op_b = dx;         op_sub = 1'b0; op_clr = 1'b1;
			end
		endcase
	end

	// one digit of the multiply-accumulate
	logic [AW+DIG_BITS-1:0] pp_full;
	logic [AW-1:0]          pp;
	logic signed [AW-1:0]   acc_next, neg_lim;
	logic                   mul_last, hit_ok, left;
	logic signed [MW-1:0]   dcr;

	assign pp_full  = {{DIG_BITS{1'b0}}, a_sh_q} * {{AW{1'b0}}, b_sh_q[DIG_BITS-1:0]};
	assign pp       = pp_full[AW-1:0];
	assign acc_next = neg_q ? (acc_q - $signed(pp)) : (acc_q + $signed(pp));
	assign mul_last = (cnt_q == CW'(NDIG - 1));
	assign neg_lim  = -acc_q;
	assign hit_ok   = !(diff_q > acc_q) && !(diff_q < neg_lim);
	assign dcr      = yje - yie;
	assign left     = (!dcr[MW-1] && (dcr != '0)) ? acc_q[AW-1]
	                                              : (!acc_q[AW-1] && (acc_q != '0));

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_DIFF_A;
			cnt_q     <= '0;
			seen_q    <= 1'b0;
			parity_q  <= 1'b0;
			hit_q     <= 1'b0;
			close_q   <= 1'b0;
			last_q    <= 1'b0;
			cross_q   <= 1'b0;
			m_valid_q <= 1'b0;
			eps_q     <= TOL_RESET[TOL_BITS-1:0];
			px_q      <= '0;
			py_q      <= '0;
		end else begin
			if (cfg_valid) begin
				eps_q <= cfg_data;
			end
			// a result issued this cycle takes the output register over
			if (m_valid_q && m_tready && (state_q != S_RESULT)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						last_q <= s_tlast;
						if (!is_vertex) begin
							px_q     <= x_in;
							py_q     <= y_in;
							seen_q   <= 1'b0;
							parity_q <= 1'b0;
							hit_q    <= 1'b0;
							if (s_tlast) state_q <= S_RESULT;
						end else if (!seen_q) begin
							seen_q  <= 1'b1;
							close_q <= 1'b0;
							if (s_tlast) state_q <= S_BOX;
						end else begin
							close_q <= s_tlast;
							state_q <= S_BOX;
						end
					end
				end
				S_BOX: begin
					cross_q <= cross_cond;
					if (hit_q) begin
						state_q <= S_NEXT;
					end else if (in_box && flat) begin
						hit_q   <= 1'b1;
						state_q <= S_NEXT;
					end else if (in_box) begin
						phase_q <= PH_DIFF_A;
						state_q <= S_LOAD;
					end else if (cross_cond) begin
						phase_q <= PH_CROSS_A;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (mul_last) begin
						case (phase_q)
							PH_DIFF_A: begin
								phase_q <= PH_DIFF_B;
								state_q <= S_LOAD;
							end
							PH_DIFF_B: begin
								phase_q <= PH_LIM;
								state_q <= S_LOAD;
							end
							PH_LIM:     state_q <= S_HITCHK;
							PH_CROSS_A: begin
								phase_q <= PH_CROSS_B;
								state_q <= S_LOAD;
							end
							PH_CROSS_B: state_q <= S_CRSCHK;
							default:    state_q <= S_NEXT;
						endcase
					end
				end
				S_HITCHK: begin
					if (hit_ok) begin
						hit_q   <= 1'b1;
						state_q <= S_NEXT;
					end else if (cross_q) begin
						phase_q <= PH_CROSS_A;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_CRSCHK: begin
					if (left) parity_q <= !parity_q;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (close_q) begin
						close_q <= 1'b0;
						state_q <= S_BOX;
					end else if (last_q) begin
						state_q <= S_RESULT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RESULT: begin
					// hold until the output register is free
					if (out_free) begin
						m_valid_q <= 1'b1;
						seen_q    <= 1'b0;
						parity_q  <= 1'b0;
						hit_q     <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc && is_vertex) begin
					if (!seen_q) begin
						first_x_q <= x_in;
						first_y_q <= y_in;
					end
					prev_x_q <= x_in;
					prev_y_q <= y_in;
					xj_q     <= seen_q ? prev_x_q : x_in;
					yj_q     <= seen_q ? prev_y_q : y_in;
					xi_q     <= x_in;
					yi_q     <= y_in;
				end
			end
			S_LOAD: begin
				a_sh_q <= {{(AW-MW){1'b0}}, mag(op_a)};
				b_sh_q <= mag(op_b);
				neg_q  <= op_a[MW-1] ^ op_b[MW-1] ^ op_sub;
				if (op_clr) acc_q <= '0;
			end
			S_MUL: begin
				a_sh_q <= a_sh_q << DIG_BITS;
				b_sh_q <= b_sh_q >> DIG_BITS;
				acc_q  <= acc_next;
				if (mul_last && (phase_q == PH_DIFF_B)) diff_q <= acc_next;
			end
			S_NEXT: begin
				// closing edge runs from the last vertex back to the first
				if (close_q) begin
					xj_q <= prev_x_q;
					yj_q <= prev_y_q;
					xi_q <= first_x_q;
					yi_q <= first_y_q;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					out_q[OUT_INSIDE_BIT] <= parity_q && !hit_q;
					out_q[OUT_BOUND_BIT]  <= hit_q;
				end
			end
			default: begin
			end
		endcase
	end

	// assertions
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (cnt_q <= CW'(NDIG - 1)))
		else $error("digit counter ran past the last digit");

	a_result_issue: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RESULT) && out_free) |=> (m_valid_q && (state_q == S_IDLE)))
		else $error("result not issued when output register was free");

	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(out_q[OUT_INSIDE_BIT] && out_q[OUT_BOUND_BIT]))
		else $error("inside and boundary flags both set");

	a_first_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && is_vertex && !seen_q && !s_tlast) |=> ((state_q == S_IDLE) && seen_q))
		else $error("first vertex did not return to idle");

	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RESULT) && out_free) |=> (!seen_q && !parity_q && !hit_q))
		else $error("polygon flags not cleared after result");

endmodule
